FILE: sv/rsst_pkg.sv
// ----------------------------------------------------------------------------
// rsst_pkg
// Shared types and constants of the RSSI-sorted scan table: record layout,
// table depth and the command group from the controller to the datapath.
// ----------------------------------------------------------------------------
package rsst_pkg;

  localparam int MAX_ENTRIES = 10;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int RD_IDX_W    = 4;
  localparam int SEL_W       = (CNT_W > RD_IDX_W) ? CNT_W : RD_IDX_W;
  localparam int COUNT_OUT_W = 4;
  localparam int KEY_W       = 49;
  localparam int LEVEL_W     = 8;
  localparam int UUID_W      = 64;

  typedef struct packed {
    logic [KEY_W-1:0]          device;
    logic signed [LEVEL_W-1:0] rssi;
    logic signed [LEVEL_W-1:0] tx_power;
    logic                      svc_listed;
    logic                      has_hrm;
    logic [UUID_W-1:0]         uuid_high;
    logic [UUID_W-1:0]         uuid_low;
  } rec_t;

  typedef struct packed {
    logic capture;
    logic match;
    logic remove;
    logic find;
    logic insert;
    logic load_out;
  } cmd_t;

endpackage

FILE: sv/rsst_ctrl.sv
// ----------------------------------------------------------------------------
// rsst_ctrl
// Sequencer of the scan table: steps a report through match, remove, find and
// insert, and holds the result beat until the output side takes it.
// ----------------------------------------------------------------------------
module rsst_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_operation,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output rsst_pkg::cmd_t  cmd
);
  import rsst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_REMOVE,
    S_FIND,
    S_INSERT,
    S_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = in_operation ? S_RESULT : S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = S_REMOVE;
      end
      S_REMOVE: begin
        cmd.remove = 1'b1;
        state_nxt  = S_FIND;
      end
      S_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = S_INSERT;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/rsst_dp.sv
// ----------------------------------------------------------------------------
// rsst_dp
// Datapath of the scan table: the record row, the key match, the shift-out of
// a refreshed record, the insertion search and the shift-in, and the result
// register.
// ----------------------------------------------------------------------------
module rsst_dp (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  rsst_pkg::cmd_t                            cmd,
  input  logic                                      in_operation,
  input  logic [rsst_pkg::KEY_W-1:0]                in_device_key,
  input  logic signed [rsst_pkg::LEVEL_W-1:0]       in_rssi,
  input  logic                                      in_tx_power_present,
  input  logic signed [rsst_pkg::LEVEL_W-1:0]       in_tx_power,
  input  logic                                      in_has_services,
  input  logic                                      in_has_hrm,
  input  logic [rsst_pkg::UUID_W-1:0]               in_uuid_high,
  input  logic [rsst_pkg::UUID_W-1:0]               in_uuid_low,
  input  logic [rsst_pkg::RD_IDX_W-1:0]             in_read_index,
  output logic [rsst_pkg::COUNT_OUT_W-1:0]          out_entry_count,
  output logic                                      out_entry_valid,
  output logic [rsst_pkg::KEY_W-1:0]                out_entry_device,
  output logic signed [rsst_pkg::LEVEL_W-1:0]       out_entry_rssi,
  output logic signed [rsst_pkg::LEVEL_W-1:0]       out_entry_tx_power,
  output logic                                      out_entry_has_services,
  output logic                                      out_entry_has_hrm,
  output logic [rsst_pkg::UUID_W-1:0]               out_entry_uuid_high,
  output logic [rsst_pkg::UUID_W-1:0]               out_entry_uuid_low
);
  import rsst_pkg::*;

  rec_t                slot_r [MAX_ENTRIES];
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;

  // Captured request
  logic                op_r;
  logic [KEY_W-1:0]    key_r;
  logic signed [LEVEL_W-1:0] rssi_r;
  logic                txp_r;
  logic signed [LEVEL_W-1:0] tx_r;
  logic                svc_r;
  logic                hrm_r;
  logic [UUID_W-1:0]   uh_r;
  logic [UUID_W-1:0]   ul_r;
  logic [SEL_W-1:0]    rd_idx_r;

  logic                found_r;
  logic                found_nxt;
  logic [IDX_W-1:0]    match_idx_r;
  logic [IDX_W-1:0]    match_idx_nxt;
  rec_t                staged_r;
  rec_t                staged_nxt;
  logic [CNT_W-1:0]    pos_r;
  logic [CNT_W-1:0]    pos_nxt;

  logic [SEL_W-1:0]    rd_addr;
  rec_t                rd_rec;
  logic                rd_hit;

  logic [COUNT_OUT_W-1:0] res_count_r;
  rec_t                   res_rec_r;
  logic                   res_valid_r;

  // Key match over the held records; the lowest position wins.
  always_comb begin
    found_nxt     = 1'b0;
    match_idx_nxt = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (CNT_W'(i) < count_r && slot_r[i].device == key_r) begin
        found_nxt     = 1'b1;
        match_idx_nxt = IDX_W'(i);
      end
    end
  end

  // One read port, shared by the refresh capture and the read request.
  assign rd_addr = cmd.remove ? SEL_W'(match_idx_r) : rd_idx_r;

  always_comb begin
    rd_rec = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (SEL_W'(i) == rd_addr) begin
        rd_rec = slot_r[i];
      end
    end
  end

  assign rd_hit = rd_idx_r < SEL_W'(count_r);

  // Merge of the report with the old record, or with a zeroed one.
  always_comb begin
    staged_nxt          = '0;
    staged_nxt.device   = key_r;
    staged_nxt.rssi     = rssi_r;
    if (txp_r) begin
      staged_nxt.tx_power = tx_r;
    end else if (found_r) begin
      staged_nxt.tx_power = rd_rec.tx_power;
    end
    if (svc_r) begin
      staged_nxt.svc_listed   = 1'b1;
      staged_nxt.has_hrm      = hrm_r;
      staged_nxt.uuid_high    = uh_r;
      staged_nxt.uuid_low     = ul_r;
    end else if (found_r) begin
      staged_nxt.uuid_high    = rd_rec.uuid_high;
      staged_nxt.uuid_low     = rd_rec.uuid_low;
    end
  end

  // Insertion point: before the first record that is strictly weaker.
  always_comb begin
    pos_nxt = count_r;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (CNT_W'(i) < count_r && slot_r[i].rssi < rssi_r) begin
        pos_nxt = CNT_W'(i);
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.remove) begin
      if (found_r) begin
        count_nxt = count_r - CNT_W'(1);
      end else if (count_r >= CNT_W'(MAX_ENTRIES)) begin
        count_nxt = CNT_W'(MAX_ENTRIES - 1);
      end
    end else if (cmd.insert) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_operation;
      key_r    <= in_device_key;
      rssi_r   <= in_rssi;
      txp_r    <= in_tx_power_present;
      tx_r     <= in_tx_power;
      svc_r    <= in_has_services;
      hrm_r    <= in_has_hrm;
      uh_r     <= in_uuid_high;
      ul_r     <= in_uuid_low;
      rd_idx_r <= SEL_W'(in_read_index);
    end
    if (cmd.match) begin
      found_r     <= found_nxt;
      match_idx_r <= match_idx_nxt;
    end
    if (cmd.remove) begin
      staged_r <= staged_nxt;
      // A refreshed record leaves the row; the records behind it close up.
      for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
        if (found_r && IDX_W'(i) >= match_idx_r && CNT_W'(i + 1) < count_r) begin
          slot_r[i] <= slot_r[i + 1];
        end
      end
    end
    if (cmd.find) begin
      pos_r <= pos_nxt;
    end
    if (cmd.insert) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (CNT_W'(i) == pos_r) begin
          slot_r[i] <= staged_r;
        end else if (i > 0 && CNT_W'(i) > pos_r && CNT_W'(i) <= count_r) begin
          slot_r[i] <= slot_r[(i > 0) ? i - 1 : 0];
        end
      end
    end
    if (cmd.load_out) begin
      res_count_r <= COUNT_OUT_W'(count_r);
      res_valid_r <= op_r && rd_hit;
      res_rec_r   <= (op_r && rd_hit) ? rd_rec : '0;
    end
  end

  assign out_entry_count        = res_count_r;
  assign out_entry_valid        = res_valid_r;
  assign out_entry_device       = res_rec_r.device;
  assign out_entry_rssi         = res_rec_r.rssi;
  assign out_entry_tx_power     = res_rec_r.tx_power;
  assign out_entry_has_services = res_rec_r.svc_listed;
  assign out_entry_has_hrm      = res_rec_r.has_hrm;
  assign out_entry_uuid_high    = res_rec_r.uuid_high;
  assign out_entry_uuid_low     = res_rec_r.uuid_low;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("record count exceeds table depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not add one record");

  a_refresh_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.remove && found_r) |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("refreshed record was not taken out");

  a_room_for_insert: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> (count_r < CNT_W'(MAX_ENTRIES) && pos_r <= count_r))
    else $error("insert without a free slot");
`endif

endmodule

FILE: sv/rssi_sorted_scan_table.sv
// ----------------------------------------------------------------------------
// rssi_sorted_scan_table
// Scan table of up to MAX_ENTRIES device records, kept strongest first.
// ----------------------------------------------------------------------------
// One item is handled at a time. A report goes from acceptance to its result
// beat through key match, take-out of a refreshed record, search for the
// insertion point, shift-in and result load; a read goes straight to the
// result load. The sequencer drives the single record row through these
// steps one by one. The next item is accepted the cycle after the result is
// loaded, even while that beat still waits on out_ready. The record row needs
// no clearing after reset: only positions below the count are ever read.
module rssi_sorted_scan_table (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic                                      in_operation,
  input  logic [rsst_pkg::KEY_W-1:0]                in_device_key,
  input  logic signed [rsst_pkg::LEVEL_W-1:0]       in_rssi,
  input  logic                                      in_tx_power_present,
  input  logic signed [rsst_pkg::LEVEL_W-1:0]       in_tx_power,
  input  logic                                      in_has_services,
  input  logic                                      in_has_hrm,
  input  logic [rsst_pkg::UUID_W-1:0]               in_uuid_high,
  input  logic [rsst_pkg::UUID_W-1:0]               in_uuid_low,
  input  logic [rsst_pkg::RD_IDX_W-1:0]             in_read_index,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [rsst_pkg::COUNT_OUT_W-1:0]          out_entry_count,
  output logic                                      out_entry_valid,
  output logic [rsst_pkg::KEY_W-1:0]                out_entry_device,
  output logic signed [rsst_pkg::LEVEL_W-1:0]       out_entry_rssi,
  output logic signed [rsst_pkg::LEVEL_W-1:0]       out_entry_tx_power,
  output logic                                      out_entry_has_services,
  output logic                                      out_entry_has_hrm,
  output logic [rsst_pkg::UUID_W-1:0]               out_entry_uuid_high,
  output logic [rsst_pkg::UUID_W-1:0]               out_entry_uuid_low
);
  import rsst_pkg::*;

  cmd_t cmd;

  rsst_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd)
  );

  rsst_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .in_operation           (in_operation),
    .in_device_key          (in_device_key),
    .in_rssi                (in_rssi),
    .in_tx_power_present    (in_tx_power_present),
    .in_tx_power            (in_tx_power),
    .in_has_services        (in_has_services),
    .in_has_hrm             (in_has_hrm),
    .in_uuid_high           (in_uuid_high),
    .in_uuid_low            (in_uuid_low),
    .in_read_index          (in_read_index),
    .out_entry_count        (out_entry_count),
    .out_entry_valid        (out_entry_valid),
    .out_entry_device       (out_entry_device),
    .out_entry_rssi         (out_entry_rssi),
    .out_entry_tx_power     (out_entry_tx_power),
    .out_entry_has_services (out_entry_has_services),
    .out_entry_has_hrm      (out_entry_has_hrm),
    .out_entry_uuid_high    (out_entry_uuid_high),
    .out_entry_uuid_low     (out_entry_uuid_low)
  );

endmodule

FILE: sim/rssi_sorted_scan_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssi_sorted_scan_table_tb
// Self-checking bench for the RSSI-sorted scan table. A short table of
// directed beats covers the empty table, the field extremes, refreshes, ties,
// eviction from a full table and out-of-range reads. Random reports over a
// small pool of device keys and random reads follow. The bench keeps its own
// copy of the table and checks every result beat in order. Both channels
// idle and stall at random, and once the receiver holds off for a long
// stretch so that the block stalls its input.
// ----------------------------------------------------------------------------
module rssi_sorted_scan_table_tb;
  import rsst_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 212;
  localparam int KEY_POOL_N   = 12;

  localparam logic [KEY_W-1:0]  KEY_MAX  = '1;
  localparam logic [UUID_W-1:0] UUID_MAX = '1;
  localparam logic [LEVEL_W-1:0] RSSI_TIES [4] = '{8'h80, 8'hC4, 8'h00, 8'h7F};

  typedef enum logic {OP_REPORT = 1'b0, OP_READ = 1'b1} scan_op_t;

  typedef struct packed {
    scan_op_t                  op;
    logic [KEY_W-1:0]          key;
    logic signed [LEVEL_W-1:0] rssi;
    logic                      tx_present;
    logic signed [LEVEL_W-1:0] tx_power;
    logic                      svc_listed;
    logic                      has_hrm;
    logic [UUID_W-1:0]         uuid_high;
    logic [UUID_W-1:0]         uuid_low;
    logic [RD_IDX_W-1:0]       read_index;
  } scan_item_t;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] count;
    logic                   valid;
    rec_t                   rec;
  } scan_result_t;

  typedef struct {
    scan_item_t   item;
    bit           typed;
    scan_result_t want;
  } directed_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_operation = 1'b0;
  logic [KEY_W-1:0]          in_device_key = '0;
  logic signed [LEVEL_W-1:0] in_rssi = '0;
  logic                      in_tx_power_present = 1'b0;
  logic signed [LEVEL_W-1:0] in_tx_power = '0;
  logic                      in_has_services = 1'b0;
  logic                      in_has_hrm = 1'b0;
  logic [UUID_W-1:0]         in_uuid_high = '0;
  logic [UUID_W-1:0]         in_uuid_low = '0;
  logic [RD_IDX_W-1:0]       in_read_index = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [COUNT_OUT_W-1:0]    out_entry_count;
  logic                      out_entry_valid;
  logic [KEY_W-1:0]          out_entry_device;
  logic signed [LEVEL_W-1:0] out_entry_rssi;
  logic signed [LEVEL_W-1:0] out_entry_tx_power;
  logic                      out_entry_has_services;
  logic                      out_entry_has_hrm;
  logic [UUID_W-1:0]         out_entry_uuid_high;
  logic [UUID_W-1:0]         out_entry_uuid_low;

  // Shadow of the table, strongest record first.
  rec_t         table_rec [MAX_ENTRIES];
  int           table_count = 0;
  scan_result_t pending_results [$];
  directed_row_t directed_rows [$];
  logic [KEY_W-1:0] key_pool [KEY_POOL_N];

  int  error_count = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;

  rssi_sorted_scan_table i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_operation           (in_operation),
    .in_device_key          (in_device_key),
    .in_rssi                (in_rssi),
    .in_tx_power_present    (in_tx_power_present),
    .in_tx_power            (in_tx_power),
    .in_has_services        (in_has_services),
    .in_has_hrm             (in_has_hrm),
    .in_uuid_high           (in_uuid_high),
    .in_uuid_low            (in_uuid_low),
    .in_read_index          (in_read_index),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_entry_count        (out_entry_count),
    .out_entry_valid        (out_entry_valid),
    .out_entry_device       (out_entry_device),
    .out_entry_rssi         (out_entry_rssi),
    .out_entry_tx_power     (out_entry_tx_power),
    .out_entry_has_services (out_entry_has_services),
    .out_entry_has_hrm      (out_entry_has_hrm),
    .out_entry_uuid_high    (out_entry_uuid_high),
    .out_entry_uuid_low     (out_entry_uuid_low)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Applies one accepted beat to the shadow table and returns its result.
  function automatic scan_result_t update_scan_table(scan_item_t it);
    scan_result_t res;
    rec_t         fresh;
    int           hit;
    int           pos;
    int           i;
    res = '0;
    if (it.op == OP_REPORT) begin
      hit = -1;
      for (i = 0; i < table_count; i++)
        if (hit < 0 && table_rec[i].device == it.key) hit = i;
      fresh = '0;
      if (hit >= 0) begin
        // A refreshed record keeps its TX power and UUID unless overwritten.
        fresh.tx_power  = table_rec[hit].tx_power;
        fresh.uuid_high = table_rec[hit].uuid_high;
        fresh.uuid_low  = table_rec[hit].uuid_low;
        for (i = hit; i + 1 < table_count; i++) table_rec[i] = table_rec[i + 1];
        table_count--;
      end else if (table_count >= MAX_ENTRIES) begin
        table_count = MAX_ENTRIES - 1;
      end
      fresh.device = it.key;
      fresh.rssi   = it.rssi;
      if (it.tx_present) fresh.tx_power = it.tx_power;
      if (it.svc_listed) begin
        fresh.svc_listed   = 1'b1;
        fresh.has_hrm      = it.has_hrm;
        fresh.uuid_high    = it.uuid_high;
        fresh.uuid_low     = it.uuid_low;
      end
      // Insert ahead of the first weaker record, so equal RSSI stays in front.
      pos = table_count;
      for (i = table_count - 1; i >= 0; i--)
        if (table_rec[i].rssi < it.rssi) pos = i;
      for (i = table_count; i > pos; i--) table_rec[i] = table_rec[i - 1];
      table_rec[pos] = fresh;
      table_count++;
    end else if (it.read_index < table_count) begin
      res.valid = 1'b1;
      res.rec   = table_rec[it.read_index];
    end
    res.count = table_count[COUNT_OUT_W-1:0];
    return res;
  endfunction

  function automatic scan_item_t report_beat(logic [KEY_W-1:0] key,
      logic [LEVEL_W-1:0] rssi, logic tx_present, logic [LEVEL_W-1:0] tx_power,
      logic svc_listed, logic has_hrm, logic [UUID_W-1:0] uuid_high,
      logic [UUID_W-1:0] uuid_low);
    scan_item_t it;
    it = '0;
    it.op           = OP_REPORT;
    it.key          = key;
    it.rssi         = rssi;
    it.tx_present   = tx_present;
    it.tx_power     = tx_power;
    it.svc_listed   = svc_listed;
    it.has_hrm      = has_hrm;
    it.uuid_high    = uuid_high;
    it.uuid_low     = uuid_low;
    return it;
  endfunction

  function automatic scan_item_t read_beat(logic [RD_IDX_W-1:0] idx);
    scan_item_t it;
    it = '0;
    it.op         = OP_READ;
    it.read_index = idx;
    return it;
  endfunction

  function automatic scan_result_t count_only(int n);
    scan_result_t res;
    res = '0;
    res.count = n[COUNT_OUT_W-1:0];
    return res;
  endfunction

  function automatic void add_row(scan_item_t it, bit typed, scan_result_t want);
    directed_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void build_directed_rows();
    scan_result_t   top_res;
    scan_result_t   tail_res;
    logic [LEVEL_W-1:0] fill_rssi [8];
    int             i;
    fill_rssi = '{8'hEC, 8'h32, 8'hEC, 8'h00, 8'h7F, 8'h9C, 8'h32, 8'h01};
    top_res  = '{count: 4'd2, valid: 1'b1,
                 rec: '{KEY_MAX, 8'sd127, 8'sd127, 1'b1, 1'b1, UUID_MAX, UUID_MAX}};
    tail_res = '{count: 4'd2, valid: 1'b1, rec: '{'0, 8'h80, 8'h00, 1'b0, 1'b0, '0, '0}};
    add_row(read_beat(4'd0), 1'b1, count_only(0));
    add_row(read_beat(4'd15), 1'b1, count_only(0));
    add_row(report_beat('0, 8'h80, 1'b0, 8'h00, 1'b0, 1'b0, '0, '0), 1'b1, count_only(1));
    add_row(report_beat(KEY_MAX, 8'h7F, 1'b1, 8'h7F, 1'b1, 1'b1, UUID_MAX, UUID_MAX),
            1'b1, count_only(2));
    add_row(read_beat(4'd0), 1'b1, top_res);
    add_row(read_beat(4'd1), 1'b1, tail_res);
    // Refresh without services: flags drop, UUID and TX power stay, tie goes behind.
    add_row(report_beat(KEY_MAX, 8'h80, 1'b0, 8'h00, 1'b0, 1'b1, '0, '0), 1'b0, '0);
    add_row(read_beat(4'd1), 1'b0, '0);
    add_row(report_beat('0, 8'h80, 1'b1, 8'h80, 1'b1, 1'b0, {1'b1, 63'd0}, 64'd1),
            1'b0, '0);
    add_row(read_beat(4'd0), 1'b0, '0);
    for (i = 1; i <= 8; i++)
      add_row(report_beat(KEY_W'(i) * 49'h1111_1111_1111, fill_rssi[i-1], i[0],
                          8'(i * 29), i[1], i[2], {$urandom, $urandom},
                          {$urandom, $urandom}), 1'b0, '0);
    // New key into a full table pushes out the weakest record.
    add_row(report_beat(49'h0ABC_DEF0_1234, 8'h3C, 1'b1, 8'hF6, 1'b1, 1'b1,
                        64'h180D, 64'h1234), 1'b0, '0);
    add_row(read_beat(4'd9), 1'b0, '0);
    add_row(read_beat(4'd10), 1'b1, count_only(10));
    add_row(report_beat(49'h3333_3333_3333, 8'h7F, 1'b0, 8'h00, 1'b1, 1'b0,
                        64'h5555, 64'hAAAA), 1'b0, '0);
    add_row(read_beat(4'd15), 1'b1, count_only(10));
    add_row(read_beat(4'd0), 1'b0, '0);
  endfunction

  // Offers one beat from a falling edge and returns at the falling edge after
  // it was accepted.
  task automatic send_item(scan_item_t it, bit typed, scan_result_t want);
    scan_result_t exp_res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_operation        <= it.op;
    in_device_key       <= it.key;
    in_rssi             <= it.rssi;
    in_tx_power_present <= it.tx_present;
    in_tx_power         <= it.tx_power;
    in_has_services     <= it.svc_listed;
    in_has_hrm          <= it.has_hrm;
    in_uuid_high        <= it.uuid_high;
    in_uuid_low         <= it.uuid_low;
    in_read_index       <= it.read_index;
    do @(posedge clk); while (!in_ready);
    exp_res = update_scan_table(it);
    pending_results.push_back(typed ? want : exp_res);
    @(negedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct);
    scan_item_t it;
    int         n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (n = 0; n < PHASE_ITEMS; n++) begin
      it.op           = ($urandom_range(99) < 35) ? OP_READ : OP_REPORT;
      it.key          = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL_N - 1)]
                                                  : KEY_W'({$urandom, $urandom});
      it.rssi         = ($urandom_range(99) < 40) ? RSSI_TIES[$urandom_range(3)]
                                                  : LEVEL_W'($urandom);
      it.tx_present   = 1'($urandom_range(1));
      it.tx_power     = LEVEL_W'($urandom);
      it.svc_listed   = ($urandom_range(99) < 70);
      it.has_hrm      = 1'($urandom_range(1));
      it.uuid_high    = {$urandom, $urandom};
      it.uuid_low     = {$urandom, $urandom};
      it.read_index   = ($urandom_range(99) < 70) ? RD_IDX_W'($urandom_range(9))
                                                  : RD_IDX_W'($urandom_range(15));
      send_item(it, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    int i;
    for (i = 0; i < KEY_POOL_N; i++) key_pool[i] = KEY_W'({$urandom, $urandom});
    build_directed_rows();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[r])
      send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
    // The long receiver hold-off lands at the start of the no-idling phase.
    hold_req = 1'b1;
    run_phase(0, 0);
    run_phase(84, 0);
    run_phase(0, 84);
    run_phase(30, 30);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : receiver
    int hold_cnt;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (hold_cnt = 1; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic compare_result(scan_result_t want, scan_result_t got);
    if (got.count !== want.count) begin
      $error("entry_count: expected %0d, got %0d", want.count, got.count);
      error_count++;
    end
    if (got.valid !== want.valid) begin
      $error("entry_valid: expected %0d, got %0d", want.valid, got.valid);
      error_count++;
    end
    if (got.rec.device !== want.rec.device) begin
      $error("entry_device: expected %0h, got %0h", want.rec.device, got.rec.device);
      error_count++;
    end
    if (got.rec.rssi !== want.rec.rssi) begin
      $error("entry_rssi: expected %0d, got %0d", want.rec.rssi, got.rec.rssi);
      error_count++;
    end
    if (got.rec.tx_power !== want.rec.tx_power) begin
      $error("entry_tx_power: expected %0d, got %0d", want.rec.tx_power, got.rec.tx_power);
      error_count++;
    end
    if (got.rec.svc_listed !== want.rec.svc_listed) begin
      $error("entry_has_services: expected %0d, got %0d",
             want.rec.svc_listed, got.rec.svc_listed);
      error_count++;
    end
    if (got.rec.has_hrm !== want.rec.has_hrm) begin
      $error("entry_has_hrm: expected %0d, got %0d", want.rec.has_hrm, got.rec.has_hrm);
      error_count++;
    end
    if (got.rec.uuid_high !== want.rec.uuid_high) begin
      $error("entry_uuid_high: expected %0h, got %0h", want.rec.uuid_high, got.rec.uuid_high);
      error_count++;
    end
    if (got.rec.uuid_low !== want.rec.uuid_low) begin
      $error("entry_uuid_low: expected %0h, got %0h", want.rec.uuid_low, got.rec.uuid_low);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    scan_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.count            = out_entry_count;
      got.valid            = out_entry_valid;
      got.rec.device       = out_entry_device;
      got.rec.rssi         = out_entry_rssi;
      got.rec.tx_power     = out_entry_tx_power;
      got.rec.svc_listed   = out_entry_has_services;
      got.rec.has_hrm      = out_entry_has_hrm;
      got.rec.uuid_high    = out_entry_uuid_high;
      got.rec.uuid_low     = out_entry_uuid_low;
      if (pending_results.size() == 0) begin
        $error("result beat with no expected result waiting");
        error_count++;
      end else begin
        compare_result(pending_results.pop_front(), got);
      end
    end
  end

endmodule

FILE: rssi_sorted_scan_table.f
sv/rsst_pkg.sv
sv/rsst_ctrl.sv
sv/rsst_dp.sv
sv/rssi_sorted_scan_table.sv
sim/rssi_sorted_scan_table_tb.sv
